@@ sv/gie_pkg.sv @@
// Shared types and constants of the GRE / IPIP IPv4 encapsulator.
// Used by every module of the block; depends on nothing.
package gie_pkg;

	// Channel payloads.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       dropped;
	} out_item_t;

	// Configuration register set.
	typedef struct packed {
		logic        encap_mode;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] ident_value;
		logic [7:0]  hop_limit;
	} cfg_t;

	// Register indexes on the configuration port.
	localparam logic [2:0] CFG_ENCAP_MODE = 3'd0;
	localparam logic [2:0] CFG_SRC_ADDR   = 3'd1;
	localparam logic [2:0] CFG_DST_ADDR   = 3'd2;
	localparam logic [2:0] CFG_IDENT      = 3'd3;
	localparam logic [2:0] CFG_HOP_LIMIT  = 3'd4;

	localparam logic        RST_ENCAP_MODE = 1'b0;
	localparam logic [31:0] RST_SRC_ADDR   = 32'hc0a8_5133;
	localparam logic [31:0] RST_DST_ADDR   = 32'hc0a8_7233;
	localparam logic [15:0] RST_IDENT      = 16'habcd;
	localparam logic [7:0]  RST_HOP_LIMIT  = 8'd64;

	// Command kinds passed from front to back.
	localparam logic [1:0] KIND_PASS  = 2'd0;
	localparam logic [1:0] KIND_DROP  = 2'd1;
	localparam logic [1:0] KIND_BURST = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} q_entry_t;

	// Outer header values prepared by the front while the head fills.
	typedef struct packed {
		logic [15:0] tot_len;
		logic [15:0] checksum;
	} hdr_info_t;

	typedef struct packed {
		logic burst_done;
	} back_status_t;

	localparam int HEAD_BYTES = 20;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	localparam logic [4:0]  HEAD_LAST_IDX  = 5'(HEAD_BYTES - 1);
	localparam logic [7:0]  IP_VER_IHL     = 8'h45;
	localparam logic [7:0]  PROTO_IPIP     = 8'd4;
	localparam logic [7:0]  PROTO_GRE      = 8'd47;
	localparam logic [7:0]  GRE_ETYPE_HI   = 8'h08;
	localparam logic [15:0] LEN_ADD_IPIP   = 16'd20;
	localparam logic [15:0] LEN_ADD_GRE    = 16'd24;
	localparam logic [5:0]  BURST_END_IPIP = 6'd39;
	localparam logic [5:0]  BURST_END_GRE  = 6'd43;
	localparam logic [5:0]  GRE_ETYPE_IDX  = 6'd22;

endpackage

@@ sv/gre_ipv4_encapsulator_unit.sv @@
// GRE / IPIP IPv4 encapsulator, top level. Depends on gie_pkg, gie_front, gie_fifo, gie_back.
// Throughput: 1 byte per cycle in pass-through while out_stall is low; the header burst
// (40 bytes IPIP, 44 GRE) leaves at 1 byte per cycle from the output register, also
// held by out_stall. The input stalls once the 4-entry command queue fills, and header
// bytes of the next packet also stall while the held head is still being read out.
// Reset (arst_n low, asynchronous): counters, queue and output valid clear; config regs reset.
module gre_ipv4_encapsulator_unit
	import gie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// inner packet request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	// encapsulated packet request channel
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t         cfg_q;
	logic         push;
	q_entry_t     push_entry;
	logic         q_full;
	logic         q_empty;
	logic         pop;
	q_entry_t     head_entry;
	hdr_info_t    hdr_info;
	back_status_t status;
	logic [4:0]   head_idx;
	logic [7:0]   head_byte;

	// Config writes must be made only while the block is idle; the block itself does
	// not enforce this and always takes them at once. Unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encap_mode          <= RST_ENCAP_MODE;
			cfg_q.source_address      <= RST_SRC_ADDR;
			cfg_q.destination_address <= RST_DST_ADDR;
			cfg_q.ident_value         <= RST_IDENT;
			cfg_q.hop_limit           <= RST_HOP_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENCAP_MODE: cfg_q.encap_mode          <= cfg_data[0];
				CFG_SRC_ADDR:   cfg_q.source_address      <= cfg_data;
				CFG_DST_ADDR:   cfg_q.destination_address <= cfg_data;
				CFG_IDENT:      cfg_q.ident_value         <= cfg_data[15:0];
				CFG_HOP_LIMIT:  cfg_q.hop_limit           <= cfg_data[7:0];
				default:        cfg_q                     <= cfg_q;
			endcase
		end
	end

	// Front: holds the inner head, builds length and checksum as bytes
	// arrive, and queues pass, burst and drop commands.
	gie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full),
		.status     (status),
		.hdr_info   (hdr_info),
		.head_idx   (head_idx),
		.head_byte  (head_byte)
	);

	// Queue lets pass-through bytes keep arriving while the back is busy.
	gie_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_entry (head_entry),
		.empty      (q_empty)
	);

	// Back: expands a burst command into header and held bytes, one per
	// cycle while out_stall is low, into the output register.
	gie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.hdr_info   (hdr_info),
		.head_entry (head_entry),
		.q_empty    (q_empty),
		.pop        (pop),
		.head_idx   (head_idx),
		.head_byte  (head_byte),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

@@ sv/gie_fifo.sv @@
// Short command queue between the front and the back of the encapsulator.
// Depends on gie_pkg for the entry type and depth.
module gie_fifo
	import gie_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output q_entry_t head_entry,
	output logic     empty
);

	q_entry_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign full       = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty      = (cnt_q == '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/gie_front.sv @@
// Front of the encapsulator: takes inner bytes, holds the first 20, prepares
// outer length and checksum, and queues pass / drop / burst commands.
// Depends on gie_pkg.
module gie_front
	import gie_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         in_valid,
	output logic         in_stall,
	input  in_item_t     in_data,
	output logic         push,
	output q_entry_t     push_entry,
	input  logic         q_full,
	input  back_status_t status,
	output hdr_info_t    hdr_info,
	input  logic [4:0]   head_idx,
	output logic [7:0]   head_byte
);

	logic [7:0]  store_q [HEAD_BYTES];
	logic [4:0]  count_q;
	logic        pass_q;
	logic        burst_pend_q;
	logic [15:0] tot_q;
	logic [19:0] sum_q;
	logic [15:0] csum_q;

	logic        accept;
	logic [15:0] len_add;
	logic [7:0]  proto;

	// Header bytes wait until the back has read out the previous head.
	assign in_stall  = q_full | (~pass_q & burst_pend_q);
	assign accept    = in_valid & ~in_stall;
	assign len_add   = cfg.encap_mode ? LEN_ADD_GRE : LEN_ADD_IPIP;
	assign proto     = cfg.encap_mode ? PROTO_GRE : PROTO_IPIP;
	assign head_byte = store_q[head_idx];
	assign hdr_info  = '{tot_len: tot_q, checksum: csum_q};

	always_comb begin
		push       = 1'b0;
		push_entry = '{kind: KIND_PASS, data: in_data.in_byte, last: in_data.in_last};
		if (accept) begin
			if (pass_q) begin
				push = 1'b1;
			end else if (count_q == HEAD_LAST_IDX) begin
				push            = 1'b1;
				push_entry.kind = KIND_BURST;
			end else if (in_data.in_last) begin
				push            = 1'b1;
				push_entry.kind = KIND_DROP;
				push_entry.data = 8'h00;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !pass_q) begin
			store_q[count_q] <= in_data.in_byte;
			// Checksum terms are added one per header byte; done by byte 9.
			case (count_q)
				5'd0: sum_q <= 20'h04500 + 20'(cfg.ident_value);
				5'd1: sum_q <= sum_q + 20'({cfg.hop_limit, proto});
				5'd2: sum_q <= sum_q + 20'(cfg.source_address[31:16]);
				5'd3: begin
					sum_q <= sum_q + 20'(cfg.source_address[15:0]);
					tot_q <= 16'({store_q[2], in_data.in_byte} + len_add);
				end
				5'd4: sum_q <= sum_q + 20'(cfg.destination_address[31:16]);
				5'd5: sum_q <= sum_q + 20'(cfg.destination_address[15:0]);
				5'd6: sum_q <= sum_q + 20'(tot_q);
				5'd7, 5'd8: sum_q <= 20'(sum_q[15:0]) + 20'(sum_q[19:16]);
				5'd9: csum_q <= ~sum_q[15:0];
				default: sum_q <= sum_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pass_q       <= 1'b0;
			burst_pend_q <= 1'b0;
		end else begin
			if (status.burst_done) begin
				burst_pend_q <= 1'b0;
			end
			if (accept) begin
				if (pass_q) begin
					if (in_data.in_last) begin
						pass_q <= 1'b0;
					end
				end else if (count_q == HEAD_LAST_IDX) begin
					count_q      <= '0;
					burst_pend_q <= 1'b1;
					pass_q       <= ~in_data.in_last;
				end else if (in_data.in_last) begin
					count_q <= '0;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ sv/gie_back.sv @@
// Back of the encapsulator: runs queued commands and drives the output
// register; a burst walks outer header, GRE header in GRE mode, and held bytes.
// Depends on gie_pkg.
module gie_back
	import gie_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  hdr_info_t    hdr_info,
	input  q_entry_t     head_entry,
	input  logic         q_empty,
	output logic         pop,
	output logic [4:0]   head_idx,
	input  logic [7:0]   head_byte,
	output back_status_t status,
	output logic         out_valid,
	input  logic         out_stall,
	output out_item_t    out_data
);

	logic       busy_q;
	logic [5:0] idx_q;
	logic       burst_last_q;
	logic       out_valid_q;
	out_item_t  out_data_q;

	logic       out_free;
	logic       at_end;
	logic [5:0] end_idx;
	logic [5:0] head_off;
	logic [7:0] burst_byte;
	logic       load;
	out_item_t  load_data;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign end_idx   = cfg.encap_mode ? BURST_END_GRE : BURST_END_IPIP;
	assign head_off  = cfg.encap_mode ? 6'(HEAD_BYTES + 4) : 6'(HEAD_BYTES);
	assign at_end    = (idx_q == end_idx);
	assign head_idx  = 5'(idx_q - head_off);
	assign pop       = ~busy_q & ~q_empty & out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign status    = '{burst_done: busy_q & out_free & at_end};

	always_comb begin
		case (idx_q)
			6'd0:  burst_byte = IP_VER_IHL;
			6'd1:  burst_byte = 8'h00;
			6'd2:  burst_byte = hdr_info.tot_len[15:8];
			6'd3:  burst_byte = hdr_info.tot_len[7:0];
			6'd4:  burst_byte = cfg.ident_value[15:8];
			6'd5:  burst_byte = cfg.ident_value[7:0];
			6'd6:  burst_byte = 8'h00;
			6'd7:  burst_byte = 8'h00;
			6'd8:  burst_byte = cfg.hop_limit;
			6'd9:  burst_byte = cfg.encap_mode ? PROTO_GRE : PROTO_IPIP;
			6'd10: burst_byte = hdr_info.checksum[15:8];
			6'd11: burst_byte = hdr_info.checksum[7:0];
			6'd12: burst_byte = cfg.source_address[31:24];
			6'd13: burst_byte = cfg.source_address[23:16];
			6'd14: burst_byte = cfg.source_address[15:8];
			6'd15: burst_byte = cfg.source_address[7:0];
			6'd16: burst_byte = cfg.destination_address[31:24];
			6'd17: burst_byte = cfg.destination_address[23:16];
			6'd18: burst_byte = cfg.destination_address[15:8];
			6'd19: burst_byte = cfg.destination_address[7:0];
			default: begin
				if (cfg.encap_mode && idx_q < head_off) begin
					// GRE header: flags/version zero, protocol type 0x0800
					burst_byte = (idx_q == GRE_ETYPE_IDX) ? GRE_ETYPE_HI : 8'h00;
				end else begin
					burst_byte = head_byte;
				end
			end
		endcase
	end

	always_comb begin
		load      = 1'b0;
		load_data = '{out_byte: head_entry.data, out_last: head_entry.last, dropped: 1'b0};
		if (busy_q) begin
			load      = 1'b1;
			load_data = '{out_byte: burst_byte, out_last: at_end & burst_last_q,
				dropped: 1'b0};
		end else if (pop) begin
			case (head_entry.kind)
				KIND_PASS: load = 1'b1;
				KIND_DROP: begin
					load      = 1'b1;
					load_data = '{out_byte: 8'h00, out_last: 1'b1, dropped: 1'b1};
				end
				default: load = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			out_data_q <= load_data;
		end
		if (pop) begin
			burst_last_q <= head_entry.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= load;
			end
			if (busy_q && out_free) begin
				if (at_end) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (pop && head_entry.kind == KIND_BURST) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

endmodule

@@ tb/sv/gre_ipv4_encapsulator_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the GRE / IPIP IPv4 encapsulator top level.
// Depends on gie_pkg and gre_ipv4_encapsulator_unit; drives inner packets
// with random gaps and stalls, and predicts every encapsulated byte.
module gre_ipv4_encapsulator_unit_tb;
	import gie_pkg::*;

	localparam int          NUM_PHASES       = 8;
	localparam int          ITEMS_PER_PHASE  = 40;
	localparam int          SETTLE_CYCLES    = 16;
	localparam int          IDLE_LIMIT       = 1000;
	localparam logic [2:0]  CFG_FIRST_UNUSED = 3'd5;
	localparam logic [7:0]  GRE_FLAGS        = 8'h00;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;

	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Inner bytes waiting to be driven, and encapsulated bytes waiting to arrive.
	in_item_t  inner_bytes_q[$];
	out_item_t encap_bytes_q[$];

	// Predictor state: tunnel settings, held head, pass-through flag.
	cfg_t       tun_cfg;
	logic [7:0] held_head [HEAD_BYTES];
	int         held_cnt;
	logic       pass_on;

	int   err_cnt;
	int   idle_cnt;
	logic in_acc = 1'b0;   // inner request taken at the last rising edge
	int   in_gap;
	int   stall_left;
	logic in_calm;
	logic out_calm;

	gre_ipv4_encapsulator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: mostly short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(3, 1);
		else if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// Expected bytes for one inner byte, appended to encap_bytes_q.
	function automatic void encapsulate_byte(in_item_t it);
		logic [7:0]  hdr [20];
		logic [15:0] tot;
		logic [31:0] sum;
		out_item_t   r;
		out_item_t   burst[$];
		int          i;

		r.dropped = 1'b0;
		if (pass_on) begin
			r.out_byte = it.in_byte;
			r.out_last = it.in_last;
			encap_bytes_q.push_back(r);
			if (it.in_last)
				pass_on = 1'b0;
			return;
		end

		if (held_cnt >= HEAD_BYTES)
			held_cnt = 0;
		held_head[held_cnt] = it.in_byte;
		held_cnt++;

		if (held_cnt < HEAD_BYTES) begin
			if (it.in_last) begin
				// too short for a header: one drop marker
				held_cnt = 0;
				r.out_byte = 8'h00;
				r.out_last = 1'b1;
				r.dropped = 1'b1;
				encap_bytes_q.push_back(r);
			end
			return;
		end

		tot = {held_head[2], held_head[3]}
			+ (tun_cfg.encap_mode ? LEN_ADD_GRE : LEN_ADD_IPIP);
		hdr[0]  = IP_VER_IHL;
		hdr[1]  = 8'h00;
		hdr[2]  = tot[15:8];
		hdr[3]  = tot[7:0];
		hdr[4]  = tun_cfg.ident_value[15:8];
		hdr[5]  = tun_cfg.ident_value[7:0];
		hdr[6]  = 8'h00;
		hdr[7]  = 8'h00;
		hdr[8]  = tun_cfg.hop_limit;
		hdr[9]  = tun_cfg.encap_mode ? PROTO_GRE : PROTO_IPIP;
		hdr[10] = 8'h00;
		hdr[11] = 8'h00;
		for (i = 0; i < 4; i++) begin
			hdr[12 + i] = tun_cfg.source_address[31 - 8 * i -: 8];
			hdr[16 + i] = tun_cfg.destination_address[31 - 8 * i -: 8];
		end
		sum = '0;
		for (i = 0; i < 20; i += 2)
			sum += 32'({hdr[i], hdr[i + 1]});
		while (sum > 32'h0000_ffff)
			sum = (sum & 32'h0000_ffff) + (sum >> 16);
		hdr[10] = ~sum[15:8];
		hdr[11] = ~sum[7:0];

		r.out_last = 1'b0;
		for (i = 0; i < 20; i++) begin
			r.out_byte = hdr[i];
			burst.push_back(r);
		end
		if (tun_cfg.encap_mode) begin
			r.out_byte = GRE_FLAGS;     burst.push_back(r);
			r.out_byte = GRE_FLAGS;     burst.push_back(r);
			r.out_byte = GRE_ETYPE_HI;  burst.push_back(r);
			r.out_byte = 8'h00;         burst.push_back(r);
		end
		for (i = 0; i < HEAD_BYTES; i++) begin
			r.out_byte = held_head[i];
			burst.push_back(r);
		end
		// exactly twenty bytes closes the packet on the burst itself
		if (it.in_last)
			burst[burst.size() - 1].out_last = 1'b1;
		else
			pass_on = 1'b1;
		held_cnt = 0;
		foreach (burst[i])
			encap_bytes_q.push_back(burst[i]);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.in_byte = b;
		it.in_last = last;
		inner_bytes_q.push_back(it);
	endtask

	// One inner packet of len bytes; header-like first bytes with a random length field.
	task automatic queue_packet(input int len);
		logic [15:0] len_field;
		logic [7:0]  b;
		int          r;
		int          k;

		r = $urandom_range(99);
		if (r < 40)
			len_field = 16'(len);
		else if (r < 60)
			len_field = 16'($urandom);
		else if (r < 70)
			len_field = 16'hffff;
		else if (r < 80)
			len_field = 16'h0000;
		else
			len_field = 16'hffe0 + 16'($urandom_range(31));
		for (k = 0; k < len; k++) begin
			b = 8'($urandom);
			if (k == 0 && $urandom_range(99) < 80)
				b = IP_VER_IHL;
			else if (k == 2)
				b = len_field[15:8];
			else if (k == 3)
				b = len_field[7:0];
			push_byte(b, k == len - 1);
		end
	endtask

	// Register write on the configuration channel; the predictor copy follows it.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ENCAP_MODE: tun_cfg.encap_mode          = val[0];
			CFG_SRC_ADDR:   tun_cfg.source_address      = val;
			CFG_DST_ADDR:   tun_cfg.destination_address = val;
			CFG_IDENT:      tun_cfg.ident_value         = val[15:0];
			CFG_HOP_LIMIT:  tun_cfg.hop_limit           = val[7:0];
			default: ;
		endcase
	endtask

	// Wait until every inner byte is taken and every expected byte has come out.
	task automatic drain();
		while (inner_bytes_q.size() != 0 || in_valid || encap_bytes_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: next inner request goes out at the falling edge once the last one is taken.
	always @(negedge clk) begin
		if (!in_valid || in_acc) begin
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (inner_bytes_q.size() != 0) begin
				in_data  <= inner_bytes_q.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(49) == 0)
					in_calm = !in_calm;
				// calm stretches send back to back
				if (in_calm || $urandom_range(99) < 55)
					in_gap = 0;
				else
					in_gap = idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls, with stretches of none.
	always @(negedge clk) begin
		if ($urandom_range(79) == 0)
			out_calm = !out_calm;
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!out_calm && $urandom_range(99) < 25) begin
			stall_left = idle_len() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: predict on each taken inner request, check each taken output request.
	always @(posedge clk) begin
		in_acc <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				encapsulate_byte(in_data);
			if (out_valid && !out_stall) begin
				if (encap_bytes_q.size() == 0) begin
					$error("unexpected output: out_byte %02h out_last %0b dropped %0b",
						out_data.out_byte, out_data.out_last, out_data.dropped);
					err_cnt++;
				end else begin
					out_item_t want;
					want = encap_bytes_q.pop_front();
					if (out_data.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h",
							want.out_byte, out_data.out_byte);
						err_cnt++;
					end
					if (out_data.out_last !== want.out_last) begin
						$error("out_last: expected %0b, got %0b",
							want.out_last, out_data.out_last);
						err_cnt++;
					end
					if (out_data.dropped !== want.dropped) begin
						$error("dropped: expected %0b, got %0b",
							want.dropped, out_data.dropped);
						err_cnt++;
					end
				end
			end
			// watchdog: cycles with no request moving on any channel
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int cnt;
		int len;
		int r;

		err_cnt = 0;
		idle_cnt = 0;
		in_gap = 0;
		stall_left = 0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		held_cnt = 0;
		pass_on = 1'b0;
		tun_cfg.encap_mode          = RST_ENCAP_MODE;
		tun_cfg.source_address      = RST_SRC_ADDR;
		tun_cfg.destination_address = RST_DST_ADDR;
		tun_cfg.ident_value         = RST_IDENT;
		tun_cfg.hop_limit           = RST_HOP_LIMIT;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: one-byte drop, three-byte drop, then an
		// exactly-twenty packet whose length field wraps the outer total length.
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b1);
		push_byte(IP_VER_IHL, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		for (int k = 4; k < HEAD_BYTES; k++)
			push_byte(k[0] ? 8'hff : 8'h00, k == HEAD_BYTES - 1);
		drain();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			// block is idle here: retune the tunnel
			if (ph == 0) begin
				// all minimum; upper mode bits set to check masking
				write_reg(CFG_ENCAP_MODE, 32'hffff_fffe);
				write_reg(CFG_SRC_ADDR, 32'h0);
				write_reg(CFG_DST_ADDR, 32'h0);
				write_reg(CFG_IDENT, 32'hffff_0000);
				write_reg(CFG_HOP_LIMIT, 32'hffff_ff00);
			end else if (ph == 1) begin
				write_reg(CFG_ENCAP_MODE, 32'hffff_ffff);
				write_reg(CFG_SRC_ADDR, 32'hffff_ffff);
				write_reg(CFG_DST_ADDR, 32'hffff_ffff);
				write_reg(CFG_IDENT, 32'hffff_ffff);
				write_reg(CFG_HOP_LIMIT, 32'hffff_ffff);
				write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(2)), $urandom);
			end else begin
				write_reg(CFG_ENCAP_MODE, $urandom);
				if ($urandom_range(1)) write_reg(CFG_SRC_ADDR, $urandom);
				if ($urandom_range(1)) write_reg(CFG_DST_ADDR, $urandom);
				if ($urandom_range(1)) write_reg(CFG_IDENT, $urandom);
				if ($urandom_range(1)) write_reg(CFG_HOP_LIMIT, $urandom);
				if ($urandom_range(3) == 0)
					write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(2)), $urandom);
			end
			@(negedge clk);
			cfg_valid <= 1'b0;

			// mostly full packets, some short ones that get dropped
			cnt = 0;
			while (cnt < ITEMS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 12)
					len = $urandom_range(HEAD_BYTES - 1, 1);
				else if (r < 30)
					len = HEAD_BYTES;
				else if (r < 85)
					len = $urandom_range(40, HEAD_BYTES + 1);
				else
					len = $urandom_range(80, 41);
				queue_packet(len);
				cnt += len;
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
